FILE: rtl/ridf_pkg.sv
// Shared types for the recent identifier pair duplicate filter.
`timescale 1ns / 1ps

package ridf_pkg;

  localparam int unsigned IdWidth = 32;
  localparam int unsigned OutBytes = 1;

  // One identifier pair; hop_id sits in the low half, as on the input stream.
  typedef struct packed {
    logic [IdWidth-1:0] end_id;
    logic [IdWidth-1:0] hop_id;
  } id_pair_t;

endpackage

FILE: rtl/ridf_ring.sv
// Ring store of recent identifier pairs: one write port, one registered read port.
`timescale 1ns / 1ps

module ridf_ring #(
  parameter int unsigned Depth = 100,
  parameter int unsigned AddrW = 7
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AddrW-1:0]  rd_addr,
  output ridf_pkg::id_pair_t rd_data,
  input  logic              wr_en,
  input  logic [AddrW-1:0]  wr_addr,
  input  ridf_pkg::id_pair_t wr_data
);
  import ridf_pkg::*;

  id_pair_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/recent_id_duplicate_filter.sv
// Top level of the recent identifier pair duplicate filter.
`timescale 1ns / 1ps

// Each request carries the hop-by-hop and end-to-end identifiers of one
// signalling message, and the block answers with one result that says whether
// the same pair is among the last RECENT_DEPTH distinct pairs it has stored.
// After reset the whole store reads as zero, so a request whose identifiers
// are both zero reports a match until every slot has been written once. On a
// miss the pair is written at the ring pointer, which advances and wraps at
// RECENT_DEPTH; on a match nothing is stored. The search walks the ring one
// entry per cycle through a single pair comparator fed from the memory's one
// registered read port; a miss walks the whole ring, and a match stops the
// walk early. Slots not yet written are tracked by a fill count rather than
// cleared, so there is no clearing pass after reset. One request is worked on
// at a time; a new request is taken as soon as the previous result has moved
// into the output register, even while that result still waits there for the
// downstream side.
module recent_id_duplicate_filter #(
  parameter int unsigned RECENT_DEPTH = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] hop_id, [63:32] end_id
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] is_retransmit, [7:1] zero
);
  import ridf_pkg::*;

  localparam int unsigned AddrW = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(RECENT_DEPTH + 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(RECENT_DEPTH);
  localparam logic [CntW-1:0]  LastCnt  = CntW'(RECENT_DEPTH - 1);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(RECENT_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  state_t            state;
  id_pair_t          pair;        // request under search
  logic [CntW-1:0]   scan_idx;    // next slot to read
  logic [CntW-1:0]   fill_cnt;    // slots written since reset, saturating
  logic [AddrW-1:0]  write_slot;  // ring pointer
  logic              rd_pend;     // a read issued last cycle, data now valid
  logic              rd_live;     // that slot has been written at least once
  logic              rd_last;     // that slot is the final one of the ring
  logic              hit;

  id_pair_t          rd_data;
  id_pair_t          cmp_b;
  logic              rd_en;
  logic              hit_now;
  logic              scan_done;
  logic              wr_en;

  // The memory port is driven straight from the scan counter.
  assign rd_en = (state == ST_SCAN) && (scan_idx < DepthCnt);

  // The single comparator: a slot never written reads as the zero pair.
  assign cmp_b     = rd_live ? rd_data : '0;
  assign hit_now   = rd_pend && (cmp_b == pair);
  assign scan_done = (state == ST_SCAN) && (hit_now || (rd_pend && rd_last));
  assign wr_en     = scan_done && !hit_now;

  assign s_axis_tready = (state == ST_IDLE);

  ridf_ring #(
    .Depth (RECENT_DEPTH),
    .AddrW (AddrW)
  ) u_ring (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[AddrW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (write_slot),
    .wr_data (pair)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan_idx      <= '0;
      fill_cnt      <= '0;
      write_slot    <= '0;
      rd_pend       <= 1'b0;
      rd_live       <= 1'b0;
      rd_last       <= 1'b0;
      hit           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
    end else begin
      // Output register empties when the downstream side takes the result,
      // unless the next result moves in at the same edge.
      if (m_axis_tvalid && m_axis_tready && (state != ST_RESULT)) begin
        m_axis_tvalid <= 1'b0;
      end

      rd_pend <= rd_en;
      rd_live <= scan_idx < fill_cnt;
      rd_last <= scan_idx == LastCnt;

      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            pair     <= s_axis_tdata;
            scan_idx <= '0;
            hit      <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (scan_done) begin
            hit   <= hit_now;
            state <= ST_RESULT;
            if (!hit_now) begin
              write_slot <= (write_slot == LastSlot) ? '0 : write_slot + 1'b1;
              if (fill_cnt != DepthCnt) begin
                fill_cnt <= fill_cnt + 1'b1;
              end
            end
          end
        end
        ST_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {7'b0, hit};
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A stored pair is never written when the search found a match.
  a_no_write_on_hit: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !hit_now)
    else $error("ring written on a matching request");

  // No read result is left in flight once the sequencer is back at rest.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !rd_pend)
    else $error("read pending while idle");

  // The fill count and ring pointer stay within the ring.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_cnt <= DepthCnt) && (CntW'(write_slot) < DepthCnt))
    else $error("fill count or ring pointer out of range");

  // Until the ring has filled once, the pointer equals the fill count.
  a_ptr_tracks_fill: assert property (@(posedge clk) disable iff (rst)
    (fill_cnt != DepthCnt) |-> (CntW'(write_slot) == fill_cnt))
    else $error("ring pointer and fill count disagree");

  // A miss moves the ring pointer on by one slot.
  a_ptr_advance: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (write_slot != $past(write_slot)))
    else $error("ring pointer did not advance after a write");

endmodule

FILE: test/recent_id_duplicate_filter_tb.sv
// Self-checking testbench for the recent identifier pair duplicate filter.
`timescale 1ns / 1ps

module recent_id_duplicate_filter_tb;
  import ridf_pkg::*;

  localparam int unsigned RingDepth = 100;
  localparam int unsigned RandomItems = 1450;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HistoryCap = 400;

  typedef struct {
    logic [31:0] hop_id;
    logic [31:0] end_id;
    bit          typed;
    bit          seen;
  } directed_row_t;

  typedef struct {
    id_pair_t pair;
    bit       seen;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = 64'h0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  recent_id_duplicate_filter #(
    .RECENT_DEPTH(RingDepth)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Directed requests. Rows with typed = 1 carry the answer worked out by hand;
  // the rest take the answer from the ring model below.
  directed_row_t directed_rows [18] = '{
    // The store comes out of reset as zeros, so the zero pair already counts.
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1},
    // Pairs that share one identifier with a stored pair must still miss.
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1},
    '{32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0},
    '{32'h0000_0000, 32'h0000_0001, 1'b1, 1'b0},
    // Most slots still hold the zero pair, so several slots match at once.
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1},
    '{32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0},
    '{32'h1234_5678, 32'h9ABC_DEF1, 1'b0, 1'b0},
    '{32'h1234_5679, 32'h9ABC_DEF0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0}
  };

  // Ring model of the recent pairs.
  logic [31:0] ring_hops [RingDepth];
  logic [31:0] ring_ends [RingDepth];
  int unsigned ring_slot;

  id_pair_t    sent_pairs [$];
  verdict_t    pending_verdicts [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req = 1'b0;
  bit          running = 1'b0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  // Looks the pair up in the ring and stores it at the ring pointer on a miss.
  function automatic bit lookup_and_store(input id_pair_t pair);
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < RingDepth; k++) begin
      if (ring_hops[k] == pair.hop_id && ring_ends[k] == pair.end_id) hit = 1'b1;
    end
    if (!hit) begin
      ring_hops[ring_slot] = pair.hop_id;
      ring_ends[ring_slot] = pair.end_id;
      ring_slot = (ring_slot + 1) % RingDepth;
    end
    return hit;
  endfunction

  function automatic logic [31:0] corner_id();
    case ($urandom_range(4))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Mix of pairs held in the ring (hits), older pairs that may have been
  // pushed out, near misses, the zero pair, corner values and fresh pairs.
  function automatic id_pair_t choose_pair();
    id_pair_t    p;
    int unsigned roll;
    int unsigned k;
    roll = $urandom_range(99);
    k = $urandom_range(RingDepth - 1);
    p.hop_id = $urandom();
    p.end_id = $urandom();
    if (roll < 30) begin
      p.hop_id = ring_hops[k];
      p.end_id = ring_ends[k];
    end else if (roll < 45 && sent_pairs.size() != 0) begin
      p = sent_pairs[$urandom_range(sent_pairs.size() - 1)];
    end else if (roll < 55) begin
      p.hop_id = ring_hops[k];
      p.end_id = ring_ends[k];
      if ($urandom_range(1) == 0) p.hop_id ^= 32'h1 << $urandom_range(31);
      else p.end_id ^= 32'h1 << $urandom_range(31);
    end else if (roll < 60) begin
      p = '0;
    end else if (roll < 65) begin
      p.hop_id = corner_id();
      p.end_id = corner_id();
    end
    return p;
  endfunction

  // Offers one request, entered and left at a falling edge. The verdict is
  // queued at the edge where the request is taken.
  task automatic send_request(input id_pair_t pair, input bit typed, input bit typed_seen);
    verdict_t v;
    bit       predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pair;
    do @(posedge clk); while (!s_axis_tready);
    predicted = lookup_and_store(pair);
    v.pair = pair;
    v.seen = typed ? typed_seen : predicted;
    pending_verdicts.push_back(v);
    sent_pairs.push_back(pair);
    if (sent_pairs.size() > HistoryCap) void'(sent_pairs.pop_front());
    @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request so the
  // block fills up and backs up its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual tdata %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.seen) begin
          $display("%0t: is_retransmit for hop %h end %h, expected %0b, actual %b",
                   $time, want.pair.hop_id, want.pair.end_id, want.seen, m_axis_tdata[0]);
          error_count++;
        end
        if (m_axis_tdata[7:1] !== 7'h0) begin
          $display("%0t: tdata padding for hop %h end %h, expected 00, actual %h",
                   $time, want.pair.hop_id, want.pair.end_id, m_axis_tdata[7:1]);
          error_count++;
        end
      end
    end
  end

  // Ends the run if no handshake happens on either side for too long.
  always @(posedge clk) begin
    if (!running || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("recent_id_duplicate_filter_tb: done, errors");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < RingDepth; k++) begin
      ring_hops[k] = '0;
      ring_ends[k] = '0;
    end
    ring_slot = 0;
    send_idle_pct = 22;
    recv_idle_pct = 79;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    running = 1'b1;

    foreach (directed_rows[i]) begin
      send_request({directed_rows[i].end_id, directed_rows[i].hop_id},
                   directed_rows[i].typed, directed_rows[i].seen);
    end

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 22;
      end
      if (n == 2 * RandomItems / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req = 1'b1;
      end
      send_request(choose_pair(), 1'b0, 1'b0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (RingDepth + 8) @(posedge clk);
    if (error_count == 0) begin
      $display("recent_id_duplicate_filter_tb: done, clean");
    end else begin
      $display("recent_id_duplicate_filter_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: recent_id_duplicate_filter.f
rtl/ridf_pkg.sv
rtl/ridf_ring.sv
rtl/recent_id_duplicate_filter.sv
test/recent_id_duplicate_filter_tb.sv
